// ----- src/acf_pkg.sv -----
// ----------------------------------------------------------------------------
// acf_pkg: shared constants and types for the autocorrelation unit
// Widths, depths and the state machine encoding.
// ----------------------------------------------------------------------------
package acf_pkg;
	localparam int MaxSamples  = 4096;
	localparam int MaxLags     = 64;
	localparam int SampleWidth = 24;
	localparam int AddrW       = $clog2(MaxSamples);
	localparam int CntW        = AddrW + 1;
	localparam int LagW        = $clog2(MaxLags);
	localparam int LagCntW     = LagW + 1;
	localparam int SumW        = SampleWidth + CntW;
	localparam int DevW        = SampleWidth + 2;
	localparam int AccW        = 2 * DevW + CntW;
	localparam int AcfW        = 48;
	localparam int MsW         = 47;
	localparam int IntW        = 64;

	localparam logic [1:0] RegNumLags = 2'd0;
	localparam logic [1:0] RegStep    = 2'd1;
	localparam logic [1:0] RegCutoff  = 2'd2;

	typedef enum logic [9:0] {
		ST_LOAD  = 10'b0000000001,
		ST_MEAN  = 10'b0000000010,
		ST_RD    = 10'b0000000100,
		ST_MAC   = 10'b0000001000,
		ST_WB    = 10'b0000010000,
		ST_DIV   = 10'b0000100000,
		ST_CUT   = 10'b0001000000,
		ST_INTG  = 10'b0010000000,
		ST_EMIT  = 10'b0100000000,
		ST_MS    = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic          start;
		logic          busy;
		logic          done;
	} div_ctl_t;
endpackage

// ----- src/acf_ram.sv -----
// ----------------------------------------------------------------------------
// acf_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module acf_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- src/acf_div.sv -----
// ----------------------------------------------------------------------------
// acf_div: signed restoring divider, truncating toward zero
// One quotient bit per cycle over the dividend width.
// ----------------------------------------------------------------------------
module acf_div
	import acf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [AccW-1:0] dividend,
	input  logic [CntW-1:0]        divisor,
	output logic                   done,
	output logic signed [AccW-1:0] quotient
);
	localparam int BitW = $clog2(AccW + 1);

	logic [AccW-1:0] q_q;
	logic [CntW:0]   r_q;
	logic [CntW-1:0] d_q;
	logic [BitW-1:0] cnt_q;
	logic            neg_q;
	logic            busy_q;
	logic [CntW:0]   r_sh;
	logic [CntW:0]   r_sub;

	assign r_sh  = {r_q[CntW-1:0], q_q[AccW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= BitW'(AccW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == BitW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[AccW-1];
			q_q   <= dividend[AccW-1] ? AccW'(-dividend) : AccW'(dividend);
			r_q   <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			if (!r_sub[CntW]) begin
				r_q <= r_sub;
				q_q <= {q_q[AccW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[AccW-2:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

// ----- src/autocorrelation_with_integral_unit.sv -----
// ----------------------------------------------------------------------------
// autocorrelation_with_integral_unit: unbiased autocorrelation with integral
// Stores a series, removes its mean, accumulates lagged products in RAM.
// ----------------------------------------------------------------------------
// Sequence: one sample loaded per cycle while in_valid is high; after the
//   last sample the mean is divided, each lagged product passes the read,
//   multiply and write-back states (sample RAM port bound), then each lag
//   sum and the mean square are divided, and the integral is summed per lag.
// Results: one series at a time; each is read from RAM, held until taken.
// Reset: async, active low; clears control state, count, sum and registers
//   to their defaults; sample RAM holds garbage, only written entries are read.
module autocorrelation_with_integral_unit
	import acf_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SampleWidth-1:0] sample,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [5:0]                    lag,
	output logic signed [AcfW-1:0]        acf_value,
	output logic                          last_lag,
	output logic [MsW-1:0]                mean_square,
	output logic signed [IntW-1:0]        integral
);
	// configuration registers
	logic [6:0]  num_lags_q;
	logic [15:0] time_step_q;
	logic [15:0] cutoff_q;

	state_t state_q;

	logic [CntW-1:0]          count_q;
	logic signed [SumW-1:0]   sum_q;
	logic signed [DevW-1:0]   mean_q;
	logic [LagCntW-1:0]       lags_q;
	logic [CntW-1:0]          i_q;      // outer index
	logic [LagCntW-1:0]       k_q;      // lag index
	logic signed [DevW-1:0]   di_q;     // d[i] latched
	logic signed [AccW-1:0]   sq_q;
	logic signed [AcfW-1:0]   acf0_q;
	logic signed [IntW-1:0]   integ_q;
	logic [MsW-1:0]           ms_q;
	logic                     cut_q;    // integral stopped
	logic                     ms_pend_q;
	logic                     div_go_q;

	// sample RAM: one port
	logic                    s_we;
	logic [AddrW-1:0]        s_addr;
	logic [SampleWidth-1:0]  s_rdata;

	acf_ram #(.Width(SampleWidth), .Depth(MaxSamples)) u_samples (
		.clk  (clk),
		.we   (s_we),
		.addr (s_addr),
		.wdata(sample),
		.rdata(s_rdata)
	);

	// lag-sum RAM, also holds acf results after division
	logic               l_we;
	logic [LagW-1:0]    l_addr;
	logic [AccW-1:0]    l_wdata;
	logic [AccW-1:0]    l_rdata;

	acf_ram #(.Width(AccW), .Depth(MaxLags)) u_lagsums (
		.clk  (clk),
		.we   (l_we),
		.addr (l_addr),
		.wdata(l_wdata),
		.rdata(l_rdata)
	);

	// shared divider: mean, lag sums, mean square
	logic                   div_done;
	logic signed [AccW-1:0] div_q;
	logic signed [AccW-1:0] div_num;
	logic [CntW-1:0]        div_den;

	acf_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_go_q),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_q)
	);

	// mean-removed sample from RAM
	logic signed [DevW-1:0] d_rd;
	assign d_rd = DevW'(signed'(s_rdata)) - mean_q;

	// product register between multiply and accumulate
	logic signed [2*DevW-1:0] prod_s1;
	logic                     first_s1;

	// saturation helpers
	logic signed [AcfW-1:0] acf_sat;
	logic [MsW-1:0]         ms_sat;
	localparam logic signed [AccW-1:0] AcfMax = AccW'((64'sd1 <<< (AcfW-1)) - 1);
	localparam logic signed [AccW-1:0] AcfMin = -AcfMax - 1;
	assign acf_sat = (div_q > AcfMax) ? AcfW'(AcfMax) :
	                 (div_q < AcfMin) ? AcfW'(AcfMin) : AcfW'(div_q);
	assign ms_sat  = (div_q < 0) ? '0 :
	                 (div_q > AcfMax) ? MsW'(AcfMax) : MsW'(div_q);

	// integral: acf[k] from RAM, acf[k+1] next read
	logic signed [AcfW-1:0]   prev_q;
	logic signed [AcfW:0]     pair_sum;
	logic signed [AcfW+17:0]  term_full;
	logic signed [AcfW+8:0]   term;
	logic signed [IntW:0]     integ_next;
	logic signed [AcfW+16:0]  cut_lhs;
	logic signed [AcfW+17:0]  cut_rhs;
	logic signed [AcfW-1:0]   cur_acf;
	assign cur_acf    = AcfW'(l_rdata);
	assign pair_sum   = (AcfW+1)'(prev_q) + (AcfW+1)'(cur_acf);
	// term is floor(s*t/512), an arithmetic shift of the full product
	assign term_full  = (AcfW+18)'(pair_sum) * $signed({2'b0, time_step_q});
	assign term       = (AcfW+9)'(term_full >>> 9);
	assign integ_next = (IntW+1)'(integ_q) + (IntW+1)'(term);
	assign cut_lhs    = {prev_q[AcfW-1], prev_q, 16'b0};
	assign cut_rhs    = (AcfW+18)'(acf0_q) * $signed({2'b0, cutoff_q});

	always_comb begin
		s_we    = 1'b0;
		s_addr  = i_q[AddrW-1:0];
		l_we    = 1'b0;
		l_addr  = k_q[LagW-1:0];
		l_wdata = '0;
		div_num = AccW'(sum_q);
		div_den = count_q;
		case (state_q)
			ST_LOAD: begin
				s_addr = count_q[AddrW-1:0];
				s_we   = in_valid && !count_q[CntW-1];
			end
			ST_RD: s_addr = AddrW'(i_q + CntW'(k_q));
			ST_WB: begin
				l_addr  = LagW'(k_q - 1'b1);
				l_we    = 1'b1;
				l_wdata = first_s1 ? AccW'(prod_s1) : l_rdata + AccW'(prod_s1);
			end
			ST_DIV: begin
				div_num = $signed(l_rdata);
				div_den = count_q - CntW'(k_q);
				if (div_done) begin
					l_we    = 1'b1;
					l_wdata = AccW'(acf_sat);
				end
			end
			ST_MS: begin
				// acf[0] on read data when the integral starts
				div_num = sq_q;
				l_addr  = '0;
			end
			ST_INTG: l_addr = LagW'(k_q + 1'b1);   // prefetch acf[k+1]
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_LOAD);

	// divider launch: last sample taken, each lag sum read back, mean square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_go_q <= 1'b0;
		end else begin
			div_go_q <= (state_q == ST_LOAD && in_valid && last_sample) ||
			            (state_q == ST_DIV && !ms_pend_q) ||
			            (state_q == ST_DIV && ms_pend_q && div_done &&
			             k_q + 1'b1 == lags_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_lags_q <= 7'd64;
			time_step_q <= 16'd256;
			cutoff_q   <= '0;
			state_q    <= ST_LOAD;
			count_q    <= '0;
			sum_q      <= '0;
			out_valid  <= 1'b0;
			ms_pend_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegNumLags: num_lags_q <= cfg_data[6:0];
					RegStep:    time_step_q <= cfg_data;
					RegCutoff:  cutoff_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_LOAD: if (in_valid) begin
					// full store drops the sample, the last flag still counts
					if (!count_q[CntW-1]) begin
						count_q <= count_q + 1'b1;
						sum_q   <= sum_q + SumW'(sample);
					end
					if (last_sample) state_q <= ST_MEAN;
				end
				ST_MEAN: if (div_done) begin
					mean_q  <= DevW'(div_q);
					i_q     <= '0;
					k_q     <= '0;
					sq_q    <= '0;
					state_q <= ST_RD;
					// lag count: zero gives 1, else clamped to MaxLags and to the series length
					if (num_lags_q == 0)
						lags_q <= LagCntW'(1);
					else if (num_lags_q > 7'(MaxLags))
						lags_q <= (count_q < CntW'(MaxLags)) ? LagCntW'(count_q) :
						          LagCntW'(MaxLags);
					else
						lags_q <= (count_q < CntW'(num_lags_q)) ? LagCntW'(count_q) :
						          LagCntW'(num_lags_q);
				end
				ST_RD: state_q <= ST_MAC;
				ST_MAC: begin
					// d[i+k] on read data; d[i] captured when k is zero
					if (k_q == 0) begin
						di_q    <= d_rd;
						prod_s1 <= d_rd * d_rd;
						sq_q    <= sq_q + AccW'(d_rd * d_rd);
					end else begin
						prod_s1 <= di_q * d_rd;
					end
					first_s1 <= (i_q == 0);
					k_q      <= k_q + 1'b1;
					state_q  <= ST_WB;
				end
				ST_WB: begin
					if (k_q == lags_q || i_q + CntW'(k_q) == count_q) begin
						k_q <= '0;
						if (i_q + 1'b1 == count_q) begin
							state_q  <= ST_DIV;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_RD;
						end
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					// wait for the RAM read of the lag sum, then launch
					if (!ms_pend_q) begin
						ms_pend_q <= 1'b1;
					end else if (div_done) begin
						ms_pend_q <= 1'b0;
						if (k_q == 0) acf0_q <= acf_sat;
						if (k_q + 1'b1 == lags_q) begin
							state_q  <= ST_MS;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_MS: if (div_done) begin
					ms_q    <= ms_sat;
					k_q     <= '0;
					integ_q <= '0;
					cut_q   <= 1'b0;
					state_q <= ST_CUT;
				end
				ST_CUT: begin
					// read data holds acf[k]; add term k-1 unless cut off
					prev_q  <= cur_acf;
					if (k_q != 0 && !cut_q) begin
						if (integ_next > (IntW+1)'(64'sh7FFF_FFFF_FFFF_FFFF))
							integ_q <= 64'sh7FFF_FFFF_FFFF_FFFF;
						else if (integ_next < -(IntW+1)'(64'sh7FFF_FFFF_FFFF_FFFF) - 1)
							integ_q <= 64'sh8000_0000_0000_0000;
						else integ_q <= IntW'(integ_next);
					end
					if (k_q + 1'b1 == lags_q) begin
						k_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_INTG;
					end
				end
				ST_INTG: begin
					// cutoff check on acf[k] before term k
					if (cutoff_q != 0 && (AcfW+18)'(cut_lhs) < cut_rhs) cut_q <= 1'b1;
					k_q     <= k_q + 1'b1;
					state_q <= ST_CUT;
				end
				ST_EMIT: begin
					// ms_pend_q: acf[k] read was issued last cycle
					if (out_valid) begin
						if (out_ready) begin
							out_valid <= 1'b0;
							if (last_lag) begin
								count_q <= '0;
								sum_q   <= '0;
								state_q <= ST_LOAD;
							end else begin
								ms_pend_q <= 1'b1;
							end
						end
					end else if (ms_pend_q) begin
						out_valid   <= 1'b1;
						ms_pend_q   <= 1'b0;
						lag         <= k_q[5:0];
						acf_value   <= cur_acf;
						last_lag    <= (k_q + 1'b1 == lags_q);
						mean_square <= (k_q + 1'b1 == lags_q) ? ms_q : '0;
						integral    <= (k_q + 1'b1 == lags_q) ? integ_q : '0;
						k_q         <= k_q + 1'b1;
					end else begin
						ms_pend_q <= 1'b1;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// ----- src/acf_checker.sv -----
// ----------------------------------------------------------------------------
// acf_checker: port-level checks for the autocorrelation unit
// Watches handshakes and result framing.
// ----------------------------------------------------------------------------
module acf_checker
	import acf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  lag,
	input logic        last_lag,
	input logic [MsW-1:0]   mean_square,
	input logic signed [IntW-1:0] integral
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while results pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lag))
		else $error("result dropped under stall");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_lag |-> mean_square == 0 && integral == 0)
		else $error("summary fields set before last");

	a_last_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_lag |=> !out_valid)
		else $error("result after last");
endmodule

bind autocorrelation_with_integral_unit acf_checker u_acf_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .lag(lag),
	.last_lag(last_lag), .mean_square(mean_square), .integral(integral)
);
